// ===== hdl/tss_pkg.sv =====
// shared types and constants of the triangle strip splitter
package tss_pkg;

  // result item codes
  typedef enum logic [1:0] {
    KIND_VERTEX    = 2'd0,
    KIND_STRIP_END = 2'd1,
    KIND_INPUT_END = 2'd2
  } kind_e;

  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned MAX_VERTS  = 4;

  localparam logic [COUNT_BITS-1:0] STRIP_MAX = '1;

  // seen_count codes
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  // everything one input item asks the back end to emit
  typedef struct packed {
    logic [2:0]                          num_verts;
    logic [MAX_VERTS-1:0][OUT_BITS-1:0]  verts;
    logic                                close_strip;
    logic                                end_input;
    logic [COUNT_BITS-1:0]               total_before;
    logic [COUNT_BITS-1:0]               total_after;
  } run_t;

endpackage

// ===== hdl/triangle_strip_splitter_core.sv =====
// A result passes through a run queue slot and then the output register on its way out.
// Throughput: one request per cycle while the run queue is not full; the back end
// issues one result per cycle while out_stall_i is low, one result of a run at a time.
// The run queue between front and back end (QUEUE_DEPTH runs) absorbs such bursts.
// Reset: asynchronous, active low; clears strip state, queue and output valid.
module triangle_strip_splitter_core
  import tss_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           vertex_index_i,
  input  logic                  final_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [OUT_BITS-1:0]   out_index_o,
  output logic [COUNT_BITS-1:0] strips_done_o,
  output logic                  last_of_run_o
);

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  run_t push_run;
  run_t head_run;

  // request classification
  tss_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_index_i (vertex_index_i),
    .final_item_i   (final_item_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .run_o          (push_run)
  );

  // run queue
  tss_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_run)
  );

  // result issue
  tss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head_run),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_index_o   (out_index_o),
    .strips_done_o (strips_done_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hdl/tss_front.sv =====
// front end: tracks the strip state across requests and turns each request into a run descriptor
module tss_front
  import tss_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         vertex_index_i,
  input  logic                final_item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output run_t                run_o
);

  logic [INDEX_BITS-1:0] older_q, older_d;
  logic [INDEX_BITS-1:0] newer_q, newer_d;
  logic                  parity_q, parity_d;
  logic [1:0]            seen_q, seen_d;
  logic                  open_q, open_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic [INDEX_BITS-1:0] idx_c;
  logic                  accept;
  logic                  nondeg;
  logic                  want_push;
  logic [COUNT_BITS-1:0] total_inc;
  run_t                  run;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign idx_c      = INDEX_BITS'(vertex_index_i);
  assign nondeg     = (older_q != newer_q) && (newer_q != idx_c) && (idx_c != older_q);
  assign total_inc  = (total_q == STRIP_MAX) ? total_q : total_q + COUNT_BITS'(1);

  // next state and run descriptor
  always_comb begin
    older_d   = older_q;
    newer_d   = newer_q;
    parity_d  = parity_q;
    seen_d    = seen_q;
    open_d    = open_q;
    total_d   = total_q;
    run       = '0;
    run.total_before = total_q;
    run.total_after  = total_inc;
    want_push = 1'b0;

    if (seen_q != SEEN_FULL && final_item_i) begin
      // short input passes through as one strip
      case (seen_q)
        SEEN_TWO: begin
          run.verts[0]  = OUT_BITS'(older_q);
          run.verts[1]  = OUT_BITS'(newer_q);
          run.verts[2]  = OUT_BITS'(idx_c);
          run.num_verts = 3'd3;
        end
        SEEN_ONE: begin
          run.verts[0]  = OUT_BITS'(newer_q);
          run.verts[1]  = OUT_BITS'(idx_c);
          run.num_verts = 3'd2;
        end
        default: begin
          run.verts[0]  = OUT_BITS'(idx_c);
          run.num_verts = 3'd1;
        end
      endcase
      run.close_strip = 1'b1;
      run.end_input   = 1'b1;
      want_push       = 1'b1;
      older_d  = '0;
      newer_d  = '0;
      parity_d = 1'b0;
      seen_d   = SEEN_NONE;
      open_d   = 1'b0;
      total_d  = '0;
    end else if (seen_q == SEEN_NONE || seen_q == SEEN_ONE) begin
      // prime the first two corners
      older_d = newer_q;
      newer_d = idx_c;
      seen_d  = seen_q + 2'd1;
    end else begin
      // full triangle
      if (nondeg) begin
        if (!open_q) begin
          run.verts[0] = OUT_BITS'(older_q);
          if (parity_q) begin
            run.verts[1]  = OUT_BITS'(older_q);
            run.verts[2]  = OUT_BITS'(newer_q);
            run.verts[3]  = OUT_BITS'(idx_c);
            run.num_verts = 3'd4;
          end else begin
            run.verts[1]  = OUT_BITS'(newer_q);
            run.verts[2]  = OUT_BITS'(idx_c);
            run.num_verts = 3'd3;
          end
          open_d = 1'b1;
        end else begin
          run.verts[0]  = OUT_BITS'(idx_c);
          run.num_verts = 3'd1;
        end
      end else if (open_q) begin
        run.close_strip = 1'b1;
        open_d          = 1'b0;
      end
      older_d  = newer_q;
      newer_d  = idx_c;
      parity_d = ~parity_q;
      seen_d   = SEEN_FULL;
      if (run.close_strip) begin
        total_d = total_inc;
      end
      if (final_item_i) begin
        // close what is still open and mark end of input
        if (open_d) begin
          run.close_strip = 1'b1;
        end
        run.end_input = 1'b1;
        older_d  = '0;
        newer_d  = '0;
        parity_d = 1'b0;
        seen_d   = SEEN_NONE;
        open_d   = 1'b0;
        total_d  = '0;
      end
      want_push = (run.num_verts != 3'd0) | run.close_strip | run.end_input;
    end
  end

  assign push_o = accept & want_push;
  assign run_o  = run;

  // strip state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      newer_q  <= '0;
      parity_q <= 1'b0;
      seen_q   <= SEEN_NONE;
      open_q   <= 1'b0;
      total_q  <= '0;
    end else if (accept) begin
      older_q  <= older_d;
      newer_q  <= newer_d;
      parity_q <= parity_d;
      seen_q   <= seen_d;
      open_q   <= open_d;
      total_q  <= total_d;
    end
  end

endmodule

// ===== hdl/tss_queue.sv =====
// small fall-through queue of run descriptors between front and back end
module tss_queue
  import tss_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output run_t head_o
);

  localparam int unsigned PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W    = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
  localparam logic [COUNT_W-1:0]  FULL_CNT  = COUNT_W'(DEPTH);

  run_t                slots_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + COUNT_W'(1);
      2'b01:   count_d = count_q - COUNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tss_back.sv =====
// back end: walks one run descriptor and issues its results into the output register
module tss_back
  import tss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  run_t                  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [OUT_BITS-1:0]   out_index_o,
  output logic [COUNT_BITS-1:0] strips_done_o,
  output logic                  last_of_run_o
);

  logic [2:0]            pos_q, pos_d;
  logic                  valid_q, valid_d;
  kind_e                 kind_q, kind_d;
  logic [OUT_BITS-1:0]   index_q, index_d;
  logic [COUNT_BITS-1:0] strips_q, strips_d;
  logic                  last_q, last_d;

  logic [2:0]            num_results;
  logic                  load;

  assign num_results = head_i.num_verts + {2'b00, head_i.close_strip}
                     + {2'b00, head_i.end_input};
  assign load        = q_valid_i & (~valid_q | ~out_stall_i);

  // pick the result at the current position of the run
  always_comb begin
    last_d = (pos_q == num_results - 3'd1);
    if (pos_q < head_i.num_verts) begin
      kind_d   = KIND_VERTEX;
      index_d  = head_i.verts[pos_q[1:0]];
      strips_d = head_i.total_before;
    end else if (head_i.close_strip && pos_q == head_i.num_verts) begin
      kind_d   = KIND_STRIP_END;
      index_d  = '0;
      strips_d = head_i.total_after;
    end else begin
      kind_d   = KIND_INPUT_END;
      index_d  = '0;
      strips_d = head_i.close_strip ? head_i.total_after : head_i.total_before;
    end
    pos_d   = load ? (last_d ? 3'd0 : pos_q + 3'd1) : pos_q;
    valid_d = load ? 1'b1 : (out_stall_i ? valid_q : 1'b0);
  end

  assign pop_o = load & last_d;

  // position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      index_q  <= index_d;
      strips_q <= strips_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign out_index_o   = index_q;
  assign strips_done_o = strips_q;
  assign last_of_run_o = last_q;

endmodule

// ===== verif/tb_top.sv =====
// testbench for triangle_strip_splitter_core: directed and random strips checked against a predictor
module tb_top;
  import tss_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 31;

  // one expected result of the splitter
  typedef struct {
    kind_e                 kind;
    logic [OUT_BITS-1:0]   vert;
    logic [COUNT_BITS-1:0] closed;
    logic                  last;
  } strip_event_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [15:0]           vertex_index_i;
  logic                  final_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            kind_o;
  logic [OUT_BITS-1:0]   out_index_o;
  logic [COUNT_BITS-1:0] strips_done_o;
  logic                  last_of_run_o;

  triangle_strip_splitter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_index_i (vertex_index_i),
    .final_item_i   (final_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_index_o    (out_index_o),
    .strips_done_o  (strips_done_o),
    .last_of_run_o  (last_of_run_o)
  );

  // predictor state of the strip being split
  logic [15:0]           corner_a;
  logic [15:0]           corner_b;
  logic                  winding_odd;
  logic [1:0]            verts_seen;
  logic                  strip_live;
  logic [COUNT_BITS-1:0] strips_closed;

  strip_event_t expected_events[$];
  strip_event_t request_events[$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void emit_event(kind_e k, logic [15:0] v);
    strip_event_t e;
    e.kind   = k;
    e.vert   = (k == KIND_VERTEX) ? v : '0;
    e.closed = strips_closed;
    e.last   = 1'b0;
    request_events.push_back(e);
  endfunction

  function automatic void close_output_strip();
    if (strips_closed != STRIP_MAX) strips_closed++;
    strip_live = 1'b0;
    emit_event(KIND_STRIP_END, '0);
  endfunction

  function automatic void clear_split_state();
    corner_a      = '0;
    corner_b      = '0;
    winding_odd   = 1'b0;
    verts_seen    = SEEN_NONE;
    strip_live    = 1'b0;
    strips_closed = '0;
  endfunction

  // expected results of one accepted request
  function automatic void split_vertex(logic [15:0] c, logic fin);
    logic [15:0] a;
    logic [15:0] b;
    a = corner_a;
    b = corner_b;
    request_events.delete();
    if (verts_seen < SEEN_FULL && fin) begin
      // short input goes through unchanged as one strip
      if (verts_seen >= SEEN_TWO) emit_event(KIND_VERTEX, a);
      if (verts_seen >= SEEN_ONE) emit_event(KIND_VERTEX, b);
      emit_event(KIND_VERTEX, c);
      close_output_strip();
      emit_event(KIND_INPUT_END, '0);
      clear_split_state();
    end else if (verts_seen < SEEN_TWO) begin
      corner_a = corner_b;
      corner_b = c;
      verts_seen++;
    end else begin
      if (a != b && b != c && c != a) begin
        // opening triangle repeats a on odd winding
        if (!strip_live) begin
          emit_event(KIND_VERTEX, a);
          if (winding_odd) emit_event(KIND_VERTEX, a);
          emit_event(KIND_VERTEX, b);
          strip_live = 1'b1;
        end
        emit_event(KIND_VERTEX, c);
      end else if (strip_live) begin
        close_output_strip();
      end
      corner_a    = b;
      corner_b    = c;
      winding_odd = ~winding_odd;
      verts_seen  = SEEN_FULL;
      if (fin) begin
        if (strip_live) close_output_strip();
        emit_event(KIND_INPUT_END, '0);
        clear_split_state();
      end
    end
    if (request_events.size() > 0) request_events[request_events.size()-1].last = 1'b1;
    foreach (request_events[i]) expected_events.push_back(request_events[i]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // send one vertex request, idling at random first
  task automatic send_vertex(input logic [15:0] v, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vertex_index_i <= v;
    final_item_i   <= fin;
    do @(posedge clk_i); while (in_stall_o);
    split_vertex(v, fin);
    @(negedge clk_i);
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    strip_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d index %0h", kind_o, out_index_o));
      end else begin
        want = expected_events[0];
        expected_events.delete(0);
        if (kind_o !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind_o, want.kind));
        if (out_index_o !== want.vert)
          report_mismatch($sformatf("out_index got %0h want %0h", out_index_o, want.vert));
        if (strips_done_o !== want.closed)
          report_mismatch($sformatf("strips_done got %0d want %0d", strips_done_o, want.closed));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run got %0b want %0b", last_of_run_o, want.last));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_events.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one, two and three index inputs at the index extremes
  task automatic test_short_inputs();
    send_vertex(16'hFFFF, 1'b1);
    send_vertex(16'h0000, 1'b0);
    send_vertex(16'hFFFF, 1'b1);
    send_vertex(16'h8001, 1'b0);
    send_vertex(16'h0000, 1'b0);
    send_vertex(16'hFFFF, 1'b1);
  endtask

  // even and odd opening, in-strip vertex, degenerate close, final inside a strip
  task automatic test_strip_shapes();
    logic [15:0] shape [11];
    shape = '{16'h0000, 16'h0014, 16'h001E, 16'h0028, 16'h0028, 16'h0032,
              16'h003C, 16'h003C, 16'h0046, 16'h0050, 16'hFFFF};
    foreach (shape[i]) send_vertex(shape[i], i == 10);
    // degenerate triangle at the final index
    send_vertex(16'h0001, 1'b0);
    send_vertex(16'h0002, 1'b0);
    send_vertex(16'h0003, 1'b0);
    send_vertex(16'h0003, 1'b1);
  endtask

  // all triangles degenerate: only the end of input comes out
  task automatic test_no_strip();
    repeat (3) send_vertex(16'h7777, 1'b0);
    send_vertex(16'h7777, 1'b1);
  endtask

  // random strips under one idling phase, small pool so that triangles often degenerate
  task automatic test_random_strips(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [15:0] pool [5];
    logic [15:0] v;
    int unsigned len;
    int unsigned pos;
    int unsigned sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (pool[k]) pool[k] = 16'($urandom());
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len = $urandom_range(8, 1);
      if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
      for (pos = 0; pos < len; pos++) begin
        if ($urandom_range(3) == 0) v = 16'($urandom());
        else v = pool[$urandom_range(4)];
        send_vertex(v, pos == len - 1);
      end
      sent += len;
    end
  endtask

  // test sequence
  initial begin : main_seq
    int unsigned n;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    vertex_index_i <= '0;
    final_item_i   <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    clear_split_state();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_inputs();
    test_strip_shapes();
    test_no_strip();
    test_random_strips(0, 0);
    test_random_strips(53, 0);
    test_random_strips(0, 53);
    test_random_strips(12, 12);

    // drain what is still in flight
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    for (n = 0; n < DRAIN_LIMIT && expected_events.size() != 0; n++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d results never came out", expected_events.size()));

    if (mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
